FILE: design/swish_activation_unit_top_defines.svh
// Assertion helpers for the swish activation unit checker.
// Each helper expects signals named clk and rst_n in the calling scope.
`ifndef SWISH_ACTIVATION_UNIT_TOP_DEFINES_SVH
`define SWISH_ACTIVATION_UNIT_TOP_DEFINES_SVH

// Overlapping implication, sampled on the rising clock edge, off during reset.
`define SWISH_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swish activation unit check failed");

// Implication that checks the consequent in the next cycle.
`define SWISH_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swish activation unit check failed");

`endif

FILE: design/swish_pkg.sv
package swish_pkg;

  // Number format and sigmoid table size.
  localparam int FRAC_BITS     = 12;
  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
  localparam int SIG_W         = FRAC_BITS + 1;
  localparam int S_W           = FRAC_BITS + 2;
  localparam int DEN_BITS      = IDX_BITS + FRAC_BITS;

  localparam logic [14:0] BETA_RESET = 15'(1 << FRAC_BITS);

  // Register map: word index taken from paddr[2].
  localparam logic CFG_IDX_BETA = 1'b0;

  // Cycles from the accepting edge to the edge that takes the result.
  localparam int PIPE_LATENCY = 8;

  typedef struct packed {
    logic              func;
    logic signed [15:0] z;
  } in_data_t;

  typedef struct packed {
    logic signed [15:0] y;
    logic               saturated;
  } out_data_t;

  // Sideband that rides along with the sigmoid lookup.
  typedef struct packed {
    logic               func;
    logic signed [15:0] z;
    logic signed [15:0] b;
    logic               flag;
  } tag_t;

  typedef struct packed {
    logic signed [15:0] val;
    logic               sat;
  } sat_res_t;

  typedef logic [SIG_W-1:0] sig_table_t [0:TABLE_ENTRIES];

  function automatic sat_res_t sat16(input logic signed [31:0] v);
    sat_res_t res;
    res.sat = 1'b0;
    res.val = v[15:0];
    if (v > 32'sd32767) begin
      res.sat = 1'b1;
      res.val = 16'sh7fff;
    end else if (v < -32'sd32768) begin
      res.sat = 1'b1;
      res.val = -16'sh8000;
    end
    return res;
  endfunction

  // Shift and subtract quotient, used only while the table is elaborated.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-r) in Q30 for 0 <= r <= 1.0, by a truncated Taylor series.
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] r);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int k = 1; k <= 24; k++) begin
      term = udiv64((term * r) >> 30, 64'(k));
      if ((k % 2) == 1) begin
        sum = (term > sum) ? 64'd0 : sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic logic [SIG_W-1:0] sigmoid_sample(input int i);
    logic signed [63:0] num;
    logic               neg;
    logic [63:0]        a;
    logic [63:0]        whole;
    logic [63:0]        rem;
    logic [63:0]        e;
    logic [63:0]        e1;
    logic [63:0]        sig;
    logic [63:0]        rnd;
    num   = 64'(i) * 64'sd65536 - 64'sd32768 * 64'(TABLE_ENTRIES);
    neg   = num[63];
    a     = neg ? 64'(-num) : 64'(num);
    whole = a >> DEN_BITS;
    rem   = a & ((64'd1 << DEN_BITS) - 64'd1);
    e     = exp_neg_q30((rem << 30) >> DEN_BITS);
    e1    = exp_neg_q30(64'd1 << 30);
    for (logic [63:0] j = 0; (j < whole) && (e != 64'd0); j++) begin
      e = (e * e1) >> 30;
    end
    if (neg) begin
      sig = udiv64(e << 30, (64'd1 << 30) + e);
    end else begin
      sig = udiv64(64'd1 << 60, (64'd1 << 30) + e);
    end
    rnd = (sig + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    return rnd[SIG_W-1:0];
  endfunction

  function automatic sig_table_t build_sig_table();
    sig_table_t t;
    for (int i = 0; i <= TABLE_ENTRIES; i++) begin
      t[i] = sigmoid_sample(i);
    end
    return t;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

FILE: design/swish_sigmoid_interp.sv
module swish_sigmoid_interp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  swish_pkg::tag_t                in_tag,
  input  logic [swish_pkg::IDX_BITS-1:0] in_idx,
  input  logic [15:0]                    in_w,
  output logic                           out_valid,
  output swish_pkg::tag_t                out_tag,
  output logic signed [swish_pkg::S_W-1:0] out_s
);

  localparam int SW  = swish_pkg::SIG_W;
  localparam int IW  = swish_pkg::IDX_BITS;
  localparam int PW  = SW + 18;

  // Stage 1: table reads at the two neighboring sample points.
  logic                 v1_r;
  swish_pkg::tag_t      tag1_r;
  logic [SW-1:0]        lo1_r;
  logic [SW-1:0]        hi1_r;
  logic [15:0]          w1_r;

  // Stage 2: slope times weight.
  logic                 v2_r;
  swish_pkg::tag_t      tag2_r;
  logic [SW-1:0]        lo2_r;
  logic signed [PW-1:0] prod2_r;

  // Stage 3: interpolated sigmoid.
  logic                 v3_r;
  swish_pkg::tag_t      tag3_r;
  logic signed [swish_pkg::S_W-1:0] s3_r;

  logic [IW:0]          idx_lo;
  logic [IW:0]          idx_hi;
  logic signed [SW:0]   diff;
  logic signed [PW-1:0] prod_full;
  logic signed [SW+1:0] step;
  logic signed [SW+1:0] s_sum;

  assign idx_lo    = {1'b0, in_idx};
  assign idx_hi    = idx_lo + (IW+1)'(1);
  assign diff      = $signed({1'b0, hi1_r}) - $signed({1'b0, lo1_r});
  assign prod_full = PW'(diff * $signed({1'b0, w1_r}));
  assign step      = prod2_r[PW-1:16];
  assign s_sum     = $signed({2'b00, lo2_r}) + step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    tag1_r  <= in_tag;
    lo1_r   <= swish_pkg::SIG_TABLE[idx_lo];
    hi1_r   <= swish_pkg::SIG_TABLE[idx_hi];
    w1_r    <= in_w;
    tag2_r  <= tag1_r;
    lo2_r   <= lo1_r;
    prod2_r <= prod_full;
    tag3_r  <= tag2_r;
    s3_r    <= s_sum[swish_pkg::S_W-1:0];
  end

  assign out_valid = v3_r;
  assign out_tag   = tag3_r;
  assign out_s     = s3_r;

endmodule

FILE: design/swish_activation_unit_top.sv
// Swish activation unit: y = z*sigmoid(beta*z), or its derivative, in signed Q4.12.
// Throughput: one item per cycle; eight register stages, one multiply at most in each.
// busy stays low, since the result side cannot stall and the pipeline never backs up.
// Synchronous active-low reset clears the valid bits and sets beta to 1.0.
module swish_activation_unit_top (
  input  logic                  clk,
  input  logic                  rst_n,
  // Item input channel.
  input  logic                  start,
  output logic                  busy,
  input  swish_pkg::in_data_t   in_data,
  // Result channel, one strobe per item.
  output logic                  out_valid,
  output swish_pkg::out_data_t  out_data,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int F  = swish_pkg::FRAC_BITS;
  localparam int SW = swish_pkg::S_W;

  // ---------------------------------------------------------------------------
  // Configuration register. The only register is beta at word zero; a write to
  // any other word is dropped and reads back as zero.
  // ---------------------------------------------------------------------------
  logic [14:0] beta_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == swish_pkg::CFG_IDX_BETA);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r <= swish_pkg::BETA_RESET;
    end else if (cfg_wr) begin
      beta_r <= pwdata[14:0];
    end
  end

  assign prdata = (paddr[2] == swish_pkg::CFG_IDX_BETA) ? {17'd0, beta_r} : 32'd0;

  // The pipeline takes an item in every cycle and the receiver cannot push
  // back, so the unit is never busy.
  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // ---------------------------------------------------------------------------
  // Stage A: scale the sample, z*beta, with beta held as a Q3.12 unsigned value.
  // ---------------------------------------------------------------------------
  logic               va_r;
  logic               funca_r;
  logic signed [15:0] za_r;
  logic signed [31:0] zb_r;

  // ---------------------------------------------------------------------------
  // Stage B: drop the fraction bits, clip b to 16 bits and split the offset
  // value b + 32768 into a table index and an interpolation weight.
  // ---------------------------------------------------------------------------
  logic                                 vb_r;
  swish_pkg::tag_t                      tagb_r;
  logic [swish_pkg::IDX_BITS-1:0]       idxb_r;
  logic [15:0]                          wb_r;

  logic signed [31:0] zb_shift;
  swish_pkg::sat_res_t b_sat;
  logic [15:0]        b_off;

  assign zb_shift = zb_r >>> F;
  assign b_sat    = swish_pkg::sat16(zb_shift);
  // Adding 32768 to a 16-bit two's complement value just flips its sign bit.
  assign b_off    = {~b_sat.val[15], b_sat.val[14:0]};

  // ---------------------------------------------------------------------------
  // Stages in the lookup unit: table read, slope times weight, sum.
  // ---------------------------------------------------------------------------
  logic                  vs;
  swish_pkg::tag_t       tags;
  logic signed [SW-1:0]  s_val;

  // ---------------------------------------------------------------------------
  // Stage C: one shared multiplier. The activation needs z*s and the
  // derivative needs s*(1-s), so the second operand is picked by func.
  // ---------------------------------------------------------------------------
  logic               vc_r;
  swish_pkg::tag_t    tagc_r;
  logic signed [SW-1:0] sc_r;
  logic signed [29:0] mc_r;

  logic signed [16:0] mul_a;
  logic signed [33:0] mul_full;

  assign mul_a    = tags.func ? (17'sd1 <<< F) - 17'(s_val) : 17'(tags.z);
  assign mul_full = 34'(17'(s_val) * mul_a);

  // ---------------------------------------------------------------------------
  // Stage D: for the derivative, u = s*(1-s) in signed Q2.12 is scaled by the clipped
  // b; for the activation the product already is the result.
  // ---------------------------------------------------------------------------
  logic               vd_r;
  logic               funcd_r;
  logic               flagd_r;
  logic signed [SW-1:0] sd_r;
  logic signed [17:0] y0d_r;
  logic signed [29:0] bud_r;

  logic signed [29:0] mc_shift;
  logic signed [SW-1:0] u_val;

  assign mc_shift = mc_r >>> F;
  assign u_val    = mc_shift[SW-1:0];

  // ---------------------------------------------------------------------------
  // Stage E: final sum for the derivative and the closing clip to 16 bits.
  // ---------------------------------------------------------------------------
  logic signed [18:0] y1_sum;
  logic signed [18:0] y_pre;
  swish_pkg::sat_res_t y_sat;

  // b*u is negative for negative b, so its scaled part keeps its sign.
  assign y1_sum = 19'(sd_r) + 19'($signed(bud_r[29:F]));
  assign y_pre  = funcd_r ? y1_sum : 19'(y0d_r);
  assign y_sat  = swish_pkg::sat16(32'(y_pre));

  logic                 vo_r;
  swish_pkg::out_data_t outd_r;

  // Valid bits move down the pipeline; payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      va_r <= accept;
      vb_r <= va_r;
      vc_r <= vs;
      vd_r <= vc_r;
      vo_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    funca_r     <= in_data.func;
    za_r        <= in_data.z;
    zb_r        <= 32'(in_data.z * $signed({1'b0, beta_r}));

    tagb_r.func <= funca_r;
    tagb_r.z    <= za_r;
    tagb_r.b    <= b_sat.val;
    tagb_r.flag <= b_sat.sat;
    idxb_r      <= b_off[15 -: swish_pkg::IDX_BITS];
    wb_r        <= {b_off[15-swish_pkg::IDX_BITS:0], swish_pkg::IDX_BITS'(0)};

    tagc_r      <= tags;
    sc_r        <= s_val;
    mc_r        <= mul_full[29:0];

    funcd_r     <= tagc_r.func;
    flagd_r     <= tagc_r.flag;
    sd_r        <= sc_r;
    y0d_r       <= mc_shift[17:0];
    bud_r       <= 30'(tagc_r.b * u_val);

    outd_r.y         <= y_sat.val;
    outd_r.saturated <= flagd_r || y_sat.sat;
  end

  swish_sigmoid_interp u_sig (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vb_r),
    .in_tag    (tagb_r),
    .in_idx    (idxb_r),
    .in_w      (wb_r),
    .out_valid (vs),
    .out_tag   (tags),
    .out_s     (s_val)
  );

  assign out_valid = vo_r;
  assign out_data  = outd_r;

endmodule

FILE: design/swish_activation_unit_checker.sv
`include "swish_activation_unit_top_defines.svh"

module swish_activation_unit_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input swish_pkg::in_data_t  in_data,
  input logic                 out_valid,
  input swish_pkg::out_data_t out_data
);

  localparam int LAT = swish_pkg::PIPE_LATENCY;

  logic acc;
  assign acc = start && !busy;

  // Every accepted item comes out after the fixed latency.
  `SWISH_ASSERT_IMP(a_result_follows, acc, ##LAT out_valid)

  // No result appears without an item accepted out of reset.
  `SWISH_ASSERT_IMP(a_no_ghost, out_valid, $past(acc && rst_n, LAT))

  // The activation of a nonnegative sample is never negative.
  `SWISH_ASSERT_IMP(a_act_sign, acc && !in_data.func && !in_data.z[15], ##LAT !out_data.y[15])

  // A zero sample has a zero activation with no clipping.
  `SWISH_ASSERT_IMP(a_act_zero, acc && !in_data.func && (in_data.z == 16'sd0),
    ##LAT ((out_data.y == 16'sd0) && !out_data.saturated))

endmodule

bind swish_activation_unit_top swish_activation_unit_checker u_swish_chk (.*);
